FILE: sv/sat_clause_count_best_flip_assert.svh
// Assertion macros used by the top-level RTL file of the clause evaluator.
`ifndef SAT_CLAUSE_COUNT_BEST_FLIP_ASSERT_SVH
`define SAT_CLAUSE_COUNT_BEST_FLIP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCBF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/scbf_pkg.sv
`timescale 1ns / 1ps

package scbf_pkg;

   localparam int NUM_VARS    = 64;
   localparam int NUM_CLAUSES = 512;
   localparam int SLOT_W      = 9;
   localparam int CNT_W       = 10;
   localparam int VAR_W       = $clog2(NUM_VARS);
   localparam int MASK_W      = 64;

   // Only the low NUM_VARS bits of a mask or an assignment take part.
   localparam logic [MASK_W-1:0] VAR_MASK = {MASK_W{1'b1}} >> (MASK_W - NUM_VARS);

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_COUNT = 2'd1;
   localparam logic [1:0] MODE_FLIP  = 2'd2;

   localparam logic REG_CLAUSES_IN_USE = 1'b0;
   localparam logic [CNT_W-1:0] CLAUSES_IN_USE_RESET = CNT_W'(NUM_CLAUSES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SELECT
   } state_type;

   typedef struct packed {
      logic clear;
      logic accumulate;
   } lane_ctl_type;

   typedef logic [NUM_VARS-1:0][CNT_W-1:0] flip_counts_type;

endpackage

FILE: sv/scbf_clause_store.sv
`timescale 1ns / 1ps

module scbf_clause_store (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [scbf_pkg::SLOT_W-1:0]         wr_addr,
   input  logic [scbf_pkg::MASK_W-1:0]         wr_pos,
   input  logic [scbf_pkg::MASK_W-1:0]         wr_neg,
   input  logic                                rd_en,
   input  logic [scbf_pkg::SLOT_W-1:0]         rd_addr,
   output logic [scbf_pkg::MASK_W-1:0]         rd_pos,
   output logic [scbf_pkg::MASK_W-1:0]         rd_neg
);

   // Each word holds the positive mask in the upper half, the negative in the lower.
   logic [2*scbf_pkg::MASK_W-1:0] mem [scbf_pkg::NUM_CLAUSES];
   logic [2*scbf_pkg::MASK_W-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_pos, wr_neg};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rd_pos = rd_word_ff[2*scbf_pkg::MASK_W-1:scbf_pkg::MASK_W];
   assign rd_neg = rd_word_ff[scbf_pkg::MASK_W-1:0];

endmodule

FILE: sv/scbf_flip_lanes.sv
`timescale 1ns / 1ps

module scbf_flip_lanes (
   input  logic                               clock,
   input  scbf_pkg::lane_ctl_type             ctl,
   input  logic [scbf_pkg::MASK_W-1:0]        clause_pos,
   input  logic [scbf_pkg::MASK_W-1:0]        clause_neg,
   input  logic [scbf_pkg::MASK_W-1:0]        assignment,
   output logic [scbf_pkg::CNT_W-1:0]         base_count,
   output scbf_pkg::flip_counts_type          flip_counts
);

   logic [scbf_pkg::CNT_W-1:0]  base_ff, base_in;
   scbf_pkg::flip_counts_type   flips_ff, flips_in;
   logic [scbf_pkg::MASK_W-1:0] hit, flip_hit;
   logic                        any_hit, one_hit;

   // A flipped clause is satisfied by its flipped literal, or by any hit
   // that does not depend on the flipped variable.
   assign hit      = ((clause_pos & assignment) | (clause_neg & ~assignment))
                     & scbf_pkg::VAR_MASK;
   assign flip_hit = ((clause_pos & ~assignment) | (clause_neg & assignment))
                     & scbf_pkg::VAR_MASK;
   assign any_hit  = |hit;
   assign one_hit  = $onehot(hit);

   always_comb begin
      base_in  = base_ff;
      flips_in = flips_ff;
      if (ctl.clear) begin
         base_in  = '0;
         flips_in = '0;
      end else if (ctl.accumulate) begin
         base_in = base_ff + scbf_pkg::CNT_W'(any_hit);
         for (int v = 0; v < scbf_pkg::NUM_VARS; v++) begin
            flips_in[v] = flips_ff[v] + scbf_pkg::CNT_W'(
               flip_hit[v] | (any_hit & ~(one_hit & hit[v])));
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      flips_ff <= flips_in;
   end

   assign base_count  = base_ff;
   assign flip_counts = flips_ff;

endmodule

FILE: sv/sat_clause_count_best_flip.sv
`timescale 1ns / 1ps
// Clause store and evaluator for local search over up to 512 clauses of 64 variables.
// Request channel: a transaction is taken on a rising edge with start high and busy
// low. Mode 0 loads one clause slot (positive and negative literal masks) in that
// single cycle and returns nothing; mode 3 is dropped. Mode 1 counts the clauses of
// the slot range, clipped at clauses_in_use, that the assignment satisfies. Mode 2
// also scores every single-variable flip and returns the best strictly better one.
// Response channel: rsp_valid is high for one cycle with the count and assignment;
// the receiver cannot hold it off, and a new request may be taken in that cycle.
// Scan: the clause memory delivers one slot per cycle, and the 65 lane counters are
// updated together for each slot. Mode 2 then walks the 64 flip counts through one
// shared comparator, one per cycle.
// Configuration: register 0 (byte address 0) is clauses_in_use, reset to 512.
// The user must write it only while the block is idle; the block does not enforce it.
// Reset returns the sequencer to idle; the clause memory is not cleared, and slots
// must be loaded before they are scanned.
`include "sat_clause_count_best_flip_assert.svh"

module sat_clause_count_best_flip (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_mode,
   input  logic [8:0]                        req_clause_slot,
   input  logic [63:0]                       req_positive_mask,
   input  logic [63:0]                       req_negative_mask,
   input  logic [63:0]                       req_assignment,
   input  logic [8:0]                        req_range_start,
   input  logic [9:0]                        req_range_length,
   output logic                              rsp_valid,
   output logic [9:0]                        rsp_satisfied_count,
   output logic [63:0]                       rsp_best_assignment,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [2:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int CNT_W  = scbf_pkg::CNT_W;
   localparam int VAR_W  = scbf_pkg::VAR_W;
   localparam int MASK_W = scbf_pkg::MASK_W;
   localparam int ADDR_W = scbf_pkg::SLOT_W + 1;

   // Configuration register.
   logic [CNT_W-1:0] clauses_in_use_ff;
   logic             csr_write;

   // Sequencer and datapath state.
   scbf_pkg::state_type state_ff, state_in;
   logic [1:0]          mode_ff, mode_in;
   logic [MASK_W-1:0]   asg_ff, asg_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   end_ff, end_in;
   logic [VAR_W-1:0]    var_ff, var_in;
   logic [CNT_W-1:0]    best_cnt_ff, best_cnt_in;
   logic [VAR_W-1:0]    best_var_ff, best_var_in;
   logic                found_ff, found_in;
   logic                rd_valid_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [MASK_W-1:0]   rsp_asg_ff, rsp_asg_in;

   // Sequencer outputs.
   logic                   accept, evaluate, load;
   logic                   issue_read, select_step, finish;
   scbf_pkg::lane_ctl_type lane_ctl;

   // Range arithmetic at acceptance.
   logic [CNT_W-1:0]  limit;
   logic [ADDR_W:0]   range_end;
   logic [ADDR_W-1:0] end_clip;

   // Memory and lane results.
   logic [MASK_W-1:0]         rd_pos, rd_neg;
   logic [CNT_W-1:0]          base_count;
   scbf_pkg::flip_counts_type flip_counts;

   // Shared comparator of the flip walk.
   logic              first_var, last_var, better;
   logic [CNT_W-1:0]  cur_best, cand_count;

   //------------------------------------------------------------------
   // Configuration port. Only the register index bit is decoded, so a
   // write to the second word is simply dropped.
   //------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clauses_in_use_ff <= scbf_pkg::CLAUSES_IN_USE_RESET;
      end else if (csr_write && paddr[2] == scbf_pkg::REG_CLAUSES_IN_USE) begin
         clauses_in_use_ff <= pwdata[CNT_W-1:0];
      end
   end

   assign prdata = (paddr[2] == scbf_pkg::REG_CLAUSES_IN_USE) ?
                   32'(clauses_in_use_ff) : '0;

   //------------------------------------------------------------------
   // Request decode.
   //------------------------------------------------------------------
   assign accept   = start & ~busy;
   assign load     = accept & (req_mode == scbf_pkg::MODE_LOAD);
   assign evaluate = accept & ((req_mode == scbf_pkg::MODE_COUNT) ||
                               (req_mode == scbf_pkg::MODE_FLIP));

   // The scan ends at the smaller of start + length and the clipped slot
   // count. An empty range is pinned to its start so the scan ends at once.
   assign limit     = (clauses_in_use_ff > CNT_W'(scbf_pkg::NUM_CLAUSES)) ?
                      CNT_W'(scbf_pkg::NUM_CLAUSES) : clauses_in_use_ff;
   assign range_end = (ADDR_W + 1)'(req_range_start) + (ADDR_W + 1)'(req_range_length);

   always_comb begin
      if (range_end > (ADDR_W + 1)'(limit)) begin
         end_clip = ADDR_W'(limit);
      end else begin
         end_clip = range_end[ADDR_W-1:0];
      end
      if (end_clip < ADDR_W'(req_range_start)) begin
         end_clip = ADDR_W'(req_range_start);
      end
   end

   //------------------------------------------------------------------
   // Sequencer: next state.
   //------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scbf_pkg::ST_IDLE: begin
            if (evaluate) begin
               state_in = scbf_pkg::ST_SCAN;
            end
         end
         scbf_pkg::ST_SCAN: begin
            if (addr_ff >= end_ff) begin
               state_in = scbf_pkg::ST_SELECT;
            end
         end
         scbf_pkg::ST_SELECT: begin
            if (mode_ff != scbf_pkg::MODE_FLIP || last_var) begin
               state_in = scbf_pkg::ST_IDLE;
            end
         end
         default: state_in = scbf_pkg::ST_IDLE;
      endcase
   end

   //------------------------------------------------------------------
   // Sequencer: outputs.
   //------------------------------------------------------------------
   always_comb begin
      busy                = 1'b1;
      issue_read          = 1'b0;
      select_step         = 1'b0;
      finish              = 1'b0;
      lane_ctl.clear      = 1'b0;
      lane_ctl.accumulate = rd_valid_ff;
      unique case (state_ff)
         scbf_pkg::ST_IDLE: begin
            busy           = 1'b0;
            lane_ctl.clear = evaluate;
         end
         scbf_pkg::ST_SCAN: begin
            issue_read = (addr_ff < end_ff);
         end
         scbf_pkg::ST_SELECT: begin
            select_step = (mode_ff == scbf_pkg::MODE_FLIP);
            finish      = (mode_ff != scbf_pkg::MODE_FLIP) || last_var;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   //------------------------------------------------------------------
   // Flip walk: one candidate compared against the running best per cycle.
   // On the first candidate the running best is the unflipped count.
   //------------------------------------------------------------------
   assign first_var  = (var_ff == '0);
   assign last_var   = (var_ff == VAR_W'(scbf_pkg::NUM_VARS - 1));
   assign cur_best   = first_var ? base_count : best_cnt_ff;
   assign cand_count = flip_counts[var_ff];
   assign better     = cand_count > cur_best;

   always_comb begin
      mode_in      = mode_ff;
      asg_in       = asg_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      var_in       = var_ff;
      best_cnt_in  = best_cnt_ff;
      best_var_in  = best_var_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      rsp_asg_in   = rsp_asg_ff;

      if (evaluate) begin
         mode_in = req_mode;
         asg_in  = req_assignment & scbf_pkg::VAR_MASK;
         addr_in = ADDR_W'(req_range_start);
         end_in  = end_clip;
         var_in  = '0;
      end

      if (issue_read) begin
         addr_in = addr_ff + ADDR_W'(1);
      end

      if (select_step) begin
         var_in      = var_ff + VAR_W'(1);
         best_cnt_in = better ? cand_count : cur_best;
         best_var_in = better ? var_ff : best_var_ff;
         found_in    = better | (~first_var & found_ff);
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
         if (mode_ff == scbf_pkg::MODE_FLIP) begin
            rsp_count_in = best_cnt_in;
            rsp_asg_in   = found_in ?
                           (asg_ff ^ (MASK_W'(1) << best_var_in)) : asg_ff;
         end else begin
            rsp_count_in = base_count;
            rsp_asg_in   = asg_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scbf_pkg::ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= issue_read;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      asg_ff       <= asg_in;
      addr_ff      <= addr_in;
      end_ff       <= end_in;
      var_ff       <= var_in;
      best_cnt_ff  <= best_cnt_in;
      best_var_ff  <= best_var_in;
      found_ff     <= found_in;
      rsp_count_ff <= rsp_count_in;
      rsp_asg_ff   <= rsp_asg_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_satisfied_count = rsp_count_ff;
   assign rsp_best_assignment = rsp_asg_ff;

   //------------------------------------------------------------------
   // Clause memory and the counting lanes.
   //------------------------------------------------------------------
   scbf_clause_store u_store (
      .clock   (clock),
      .wr_en   (load),
      .wr_addr (req_clause_slot),
      .wr_pos  (req_positive_mask),
      .wr_neg  (req_negative_mask),
      .rd_en   (issue_read),
      .rd_addr (addr_ff[scbf_pkg::SLOT_W-1:0]),
      .rd_pos  (rd_pos),
      .rd_neg  (rd_neg)
   );

   scbf_flip_lanes u_lanes (
      .clock       (clock),
      .ctl         (lane_ctl),
      .clause_pos  (rd_pos),
      .clause_neg  (rd_neg),
      .assignment  (asg_ff),
      .base_count  (base_count),
      .flip_counts (flip_counts)
   );

   //------------------------------------------------------------------
   // Assertions.
   //------------------------------------------------------------------
   `SCBF_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid_ff,
      state_ff == scbf_pkg::ST_IDLE, "result strobe outside idle")
   `SCBF_ASSERT_NEXT(a_eval_goes_busy, clock, reset, evaluate,
      busy && state_ff == scbf_pkg::ST_SCAN, "evaluation did not start a scan")
   `SCBF_ASSERT_SAME(a_scan_in_range, clock, reset, state_ff == scbf_pkg::ST_SCAN,
      addr_ff <= end_ff, "scan address passed the range end")
   `SCBF_ASSERT_SAME(a_read_only_in_scan, clock, reset, rd_valid_ff,
      state_ff == scbf_pkg::ST_SCAN, "clause data arrived outside the scan")

endmodule

FILE: sim/sat_clause_count_best_flip_checker.sv
`timescale 1ns / 1ps

module sat_clause_count_best_flip_checker
   import scbf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [SLOT_W-1:0] req_clause_slot,
   input  logic [MASK_W-1:0] req_positive_mask,
   input  logic [MASK_W-1:0] req_negative_mask,
   input  logic [MASK_W-1:0] req_assignment,
   input  logic [SLOT_W-1:0] req_range_start,
   input  logic [CNT_W-1:0]  req_range_length,
   input  logic              rsp_valid,
   input  logic [CNT_W-1:0]  rsp_satisfied_count,
   input  logic [MASK_W-1:0] rsp_best_assignment,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int unsigned       mismatch_count,
   output int unsigned       results_pending
);

   localparam logic [2:0] CLAUSES_IN_USE_ADDR = 3'(REG_CLAUSES_IN_USE) << 2;

   typedef struct packed {
      logic [CNT_W-1:0]  satisfied;
      logic [MASK_W-1:0] assignment;
   } search_result_type;

   logic [MASK_W-1:0] positive_lits [NUM_CLAUSES];
   logic [MASK_W-1:0] negative_lits [NUM_CLAUSES];
   logic [CNT_W-1:0]  clause_bound = CLAUSES_IN_USE_RESET;
   search_result_type awaited_results [$];
   int unsigned       failures = 0;

   // Satisfied clauses of the range, clipped at the clauses in use.
   function automatic int unsigned tally_clauses(input logic [MASK_W-1:0] asg,
         input int unsigned first, input int unsigned span);
      int unsigned       bound;
      int unsigned       stop;
      int unsigned       tally;
      logic [MASK_W-1:0] hit;
      bound = (clause_bound > NUM_CLAUSES) ? NUM_CLAUSES : clause_bound;
      stop  = (first + span > bound) ? bound : first + span;
      tally = 0;
      for (int unsigned i = first; i < stop; i++) begin
         hit = (positive_lits[i] & asg) | (negative_lits[i] & ~asg);
         if ((hit & VAR_MASK) != '0) tally++;
      end
      return tally;
   endfunction

   // Scores the assignment and, for a flip search, every single-variable neighbour in
   // ascending order; only a strictly higher count displaces the current best.
   function automatic search_result_type search_neighbourhood(input logic [1:0] mode,
         input logic [MASK_W-1:0] asg, input int unsigned first, input int unsigned span);
      logic [MASK_W-1:0] origin;
      logic [MASK_W-1:0] trial;
      int unsigned       best_tally;
      int unsigned       trial_tally;
      search_result_type best;
      origin          = asg & VAR_MASK;
      best_tally      = tally_clauses(origin, first, span);
      best.assignment = origin;
      if (mode == MODE_FLIP) begin
         for (int v = 0; v < NUM_VARS; v++) begin
            trial       = origin ^ (MASK_W'(1) << v);
            trial_tally = tally_clauses(trial, first, span);
            if (trial_tally > best_tally) begin
               best_tally      = trial_tally;
               best.assignment = trial;
            end
         end
      end
      best.satisfied = CNT_W'(best_tally);
      return best;
   endfunction

   always @(posedge clock) begin
      search_result_type awaited;
      if (reset) begin
         awaited_results.delete();
         clause_bound = CLAUSES_IN_USE_RESET;
      end else begin
         // Results are checked before this edge's request is predicted, since the block
         // may take a new transaction in the cycle that it presents a result.
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               failures++;
               $error("unexpected result: satisfied_count %0d, best_assignment %h",
                      rsp_satisfied_count, rsp_best_assignment);
            end else begin
               awaited = awaited_results.pop_front();
               if (rsp_satisfied_count !== awaited.satisfied) begin
                  failures++;
                  $error("satisfied_count: expected %0d, actual %0d",
                         awaited.satisfied, rsp_satisfied_count);
               end
               if (rsp_best_assignment !== awaited.assignment) begin
                  failures++;
                  $error("best_assignment: expected %h, actual %h",
                         awaited.assignment, rsp_best_assignment);
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr == CLAUSES_IN_USE_ADDR)
            clause_bound = pwdata[CNT_W-1:0];
         if (start && !busy) begin
            case (req_mode)
               MODE_LOAD: begin
                  // A nine-bit slot can never exceed the store, so every load lands.
                  positive_lits[req_clause_slot] = req_positive_mask;
                  negative_lits[req_clause_slot] = req_negative_mask;
               end
               MODE_COUNT, MODE_FLIP: begin
                  awaited_results.push_back(search_neighbourhood(req_mode, req_assignment,
                                            req_range_start, req_range_length));
               end
               default: begin
                  // The reserved mode is dropped and owes no result.
               end
            endcase
         end
      end
      results_pending <= awaited_results.size();
      mismatch_count  <= failures;
   end

endmodule

FILE: sim/sat_clause_count_best_flip_tb.sv
`timescale 1ns / 1ps

module sat_clause_count_best_flip_tb;
   import scbf_pkg::*;

   // The slowest legal transaction is a full-range flip search, and the whole run holds
   // under five hundred transactions, so this bound leaves several times the worst case
   // before the run is declared hung.
   localparam int unsigned CYCLE_LIMIT   = 4_000_000;
   localparam int          RESET_CYCLES  = 5;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          RANDOM_ITEMS  = 300;
   localparam int          PHASE_COUNT   = 6;
   // Slots loaded before anything is scanned: a block at the bottom of the store, where
   // the random phases work, and a few at the very top for the end-of-store ranges.
   localparam int          LIVE_SLOTS    = 128;
   localparam int          TOP_SLOTS     = 12;
   localparam logic [1:0]  MODE_RESERVED = 2'd3;
   localparam logic [2:0]  CLAUSES_IN_USE_ADDR = 3'(REG_CLAUSES_IN_USE) << 2;
   // Byte address of register index 1, which does not exist; writes there must vanish.
   localparam logic [2:0]  SPARE_REG_ADDR = 3'd4;

   typedef struct packed {
      logic [MASK_W-1:0] positive;
      logic [MASK_W-1:0] negative;
   } clause_masks_type;

   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              start             = 1'b0;
   logic              busy;
   logic [1:0]        req_mode          = MODE_LOAD;
   logic [SLOT_W-1:0] req_clause_slot   = '0;
   logic [MASK_W-1:0] req_positive_mask = '0;
   logic [MASK_W-1:0] req_negative_mask = '0;
   logic [MASK_W-1:0] req_assignment    = '0;
   logic [SLOT_W-1:0] req_range_start   = '0;
   logic [CNT_W-1:0]  req_range_length  = '0;
   logic              rsp_valid;
   logic [CNT_W-1:0]  rsp_satisfied_count;
   logic [MASK_W-1:0] rsp_best_assignment;
   logic              psel              = 1'b0;
   logic              penable           = 1'b0;
   logic              pwrite            = 1'b0;
   logic [2:0]        paddr             = '0;
   logic [31:0]       pwdata            = '0;
   logic [31:0]       prdata;
   logic              pready;

   int unsigned       mismatch_count;
   int unsigned       results_pending;
   int unsigned       cycle_count = 0;
   // The stimulus keeps its own note of clauses_in_use so that it can aim ranges at the
   // live part of the store; idling is switched off for the closing phase.
   int unsigned       bound_now   = NUM_CLAUSES;
   bit                idling_on   = 1'b1;

   sat_clause_count_best_flip dut (.*);

   sat_clause_count_best_flip_checker checker_inst (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [MASK_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic clause_masks_type clause_of(input logic [MASK_W-1:0] positive,
         input logic [MASK_W-1:0] negative);
      clause_masks_type masks;
      masks.positive = positive;
      masks.negative = negative;
      return masks;
   endfunction

   // Mostly short clauses of one to three literals, as a local search would see them,
   // so that flips genuinely change the count. Half of them crowd onto the first eight
   // variables, which makes flips interfere with one another. A few are empty (never
   // satisfied), dense random, or tautologies holding both polarities of one variable.
   function automatic clause_masks_type random_clause();
      clause_masks_type masks;
      int unsigned      kind;
      int unsigned      reach;
      int unsigned      v;
      masks = '0;
      kind  = $urandom_range(0, 99);
      reach = $urandom_range(0, 1) ? 7 : NUM_VARS - 1;
      if (kind >= 14) begin
         repeat ($urandom_range(1, 3)) begin
            v = $urandom_range(0, reach);
            if ($urandom_range(0, 1)) masks.positive[v] = 1'b1;
            else masks.negative[v] = 1'b1;
         end
      end else if (kind >= 10) begin
         v              = $urandom_range(0, NUM_VARS - 1);
         masks.positive = MASK_W'(1) << v;
         masks.negative = masks.positive;
      end else if (kind >= 5) begin
         masks = clause_of(random_word(), random_word());
      end
      return masks;
   endfunction

   function automatic logic [MASK_W-1:0] random_assignment();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return random_word();
      endcase
   endfunction

   // Presents one transaction from the current rising edge and returns at the edge that
   // accepts it, with start still high so that a following transaction can go straight
   // out without a gap.
   task automatic issue_request(input logic [1:0] mode, input logic [SLOT_W-1:0] slot,
         input clause_masks_type masks, input logic [MASK_W-1:0] asg,
         input logic [SLOT_W-1:0] first, input logic [CNT_W-1:0] span);
      req_mode          <= mode;
      req_clause_slot   <= slot;
      req_positive_mask <= masks.positive;
      req_negative_mask <= masks.negative;
      req_assignment    <= asg;
      req_range_start   <= first;
      req_range_length  <= span;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Fields that a mode does not use still carry random values, so that the block is
   // seen to ignore them.
   task automatic load_clause(input logic [SLOT_W-1:0] slot, input clause_masks_type masks);
      issue_request(MODE_LOAD, slot, masks, random_word(), SLOT_W'($urandom),
                    CNT_W'($urandom));
   endtask

   task automatic evaluate(input logic [1:0] mode, input logic [MASK_W-1:0] asg,
         input logic [SLOT_W-1:0] first, input logic [CNT_W-1:0] span);
      issue_request(mode, SLOT_W'($urandom), clause_of(random_word(), random_word()),
                    asg, first, span);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if (idling_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 3));
   endtask

   // Holds the sender until every predicted result has come back. Loads return nothing,
   // so a few further cycles and a low busy are also awaited before the block counts as
   // idle.
   task automatic wait_for_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands on the access edge with pready high.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == CLAUSES_IN_USE_ADDR) bound_now = value[CNT_W-1:0];
   endtask

   task automatic set_bound(input int unsigned value);
      wait_for_quiet();
      write_register(CLAUSES_IN_USE_ADDR, 32'(value));
   endtask

   // One random transaction. Most ranges are short and start inside the live part of the
   // store; some start anywhere, so that ranges beyond the bound and ranges running past
   // it both occur, and a few have spans of up to the whole store.
   task automatic random_item();
      int unsigned pick;
      int unsigned shape;
      int unsigned first;
      int unsigned span;
      pick  = $urandom_range(0, 99);
      shape = $urandom_range(0, 99);
      if (shape < 75) begin
         first = (bound_now > 0) ? $urandom_range(0, bound_now - 1)
                                 : $urandom_range(0, NUM_CLAUSES - 1);
         span  = $urandom_range(0, 32);
      end else if (shape < 88) begin
         first = $urandom_range(0, NUM_CLAUSES - 1);
         span  = $urandom_range(0, 80);
      end else begin
         first = $urandom_range(0, NUM_CLAUSES - 1);
         span  = $urandom_range(0, NUM_CLAUSES);
      end
      if (pick < 30) begin
         load_clause(SLOT_W'($urandom_range(0, NUM_CLAUSES - 1)), random_clause());
      end else if (pick < 96) begin
         evaluate((pick < 60) ? MODE_COUNT : MODE_FLIP, random_assignment(),
                  SLOT_W'(first), CNT_W'(span));
      end else begin
         issue_request(MODE_RESERVED, SLOT_W'($urandom),
                       clause_of(random_word(), random_word()), random_word(),
                       SLOT_W'(first), CNT_W'(span));
      end
      maybe_idle();
   endtask

   initial begin
      int unsigned phase_bounds [PHASE_COUNT];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset leaves the clause store as it was, so the bottom block and the top few
      // slots are loaded before anything is scanned. Under the full bound only ranges
      // inside those slots are scanned, and the random phases keep clauses_in_use at or
      // below the bottom block, so no range can touch an unwritten slot.
      for (int slot = 0; slot < LIVE_SLOTS; slot++) begin
         load_clause(SLOT_W'(slot), random_clause());
         maybe_idle();
      end
      for (int slot = NUM_CLAUSES - TOP_SLOTS; slot < NUM_CLAUSES; slot++) begin
         load_clause(SLOT_W'(slot), random_clause());
         maybe_idle();
      end

      // Directed transactions. Slot 0 holds every positive literal and the last slot every
      // negative one; slot 1 is an empty clause; slot 2 is a tautology on the top
      // variable. Slots 3 and 4 both want variable 20 true, so from the all-false
      // assignment that flip gains two clauses. Slots 5 and 6 want variables 3 and 7
      // true, giving a tie in which the lower variable must win.
      load_clause(9'd0, clause_of('1, '0));
      load_clause(SLOT_W'(NUM_CLAUSES - 1), clause_of('0, '1));
      load_clause(9'd1, clause_of('0, '0));
      load_clause(9'd2, clause_of(MASK_W'(1) << 63, MASK_W'(1) << 63));
      load_clause(9'd3, clause_of(MASK_W'(1) << 20, '0));
      load_clause(9'd4, clause_of(MASK_W'(1) << 20, '0));
      load_clause(9'd5, clause_of(MASK_W'(1) << 3, '0));
      load_clause(9'd6, clause_of(MASK_W'(1) << 7, '0));
      evaluate(MODE_COUNT, '0, 9'd0, 10'd0);
      evaluate(MODE_COUNT, '1, 9'd0, CNT_W'(LIVE_SLOTS));
      evaluate(MODE_FLIP, '0, 9'd3, 10'd2);
      evaluate(MODE_FLIP, '0, 9'd5, 10'd2);
      evaluate(MODE_FLIP, '1, 9'd0, 10'd8);
      evaluate(MODE_COUNT, random_word(), 9'd511, 10'd1);
      evaluate(MODE_COUNT, '0, 9'd511, 10'd512);
      evaluate(MODE_FLIP, random_word(), 9'd0, CNT_W'(LIVE_SLOTS));
      issue_request(MODE_RESERVED, 9'd0, clause_of('1, '1), '1, 9'd0, 10'd512);

      // No clauses in use: every range is empty and a flip search returns its input.
      set_bound(0);
      evaluate(MODE_COUNT, '1, 9'd0, 10'd512);
      evaluate(MODE_FLIP, '0, 9'd5, 10'd2);

      // A single clause in use: a range starting at slot 1 lies wholly beyond the bound.
      set_bound(1);
      evaluate(MODE_COUNT, '1, 9'd0, 10'd5);
      evaluate(MODE_FLIP, '0, 9'd1, 10'd3);

      // A write to a register that does not exist must leave the bound at one.
      wait_for_quiet();
      write_register(SPARE_REG_ADDR, 32'd300);
      evaluate(MODE_COUNT, '1, 9'd0, 10'd512);

      // Back to the full store: the tautology is satisfied whatever the assignment, so no
      // flip can improve on it, and the last range ends exactly at the store's end.
      set_bound(NUM_CLAUSES);
      evaluate(MODE_FLIP, MASK_W'(1) << 63, 9'd2, 10'd1);
      evaluate(MODE_COUNT, random_word(), 9'd500, 10'd12);

      // Random phases, each under its own clauses_in_use, the extremes among them. The
      // first phase stops once part-way until every result is back; the closing phase runs
      // without idling so that transactions also go out back to back.
      phase_bounds = '{LIVE_SLOTS, 48, 0, LIVE_SLOTS - 1, 1,
                       $urandom_range(2, LIVE_SLOTS)};
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         set_bound(phase_bounds[phase]);
         idling_on = (phase != PHASE_COUNT - 1);
         for (int item = 0; item < RANDOM_ITEMS / PHASE_COUNT; item++) begin
            random_item();
            if (phase == 0 && item == 40) wait_for_quiet();
         end
      end

      wait_for_quiet();
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: sat_clause_count_best_flip.f
+incdir+sv
sv/scbf_pkg.sv
sv/scbf_clause_store.sv
sv/scbf_flip_lanes.sv
sv/sat_clause_count_best_flip.sv
sim/sat_clause_count_best_flip_checker.sv
sim/sat_clause_count_best_flip_tb.sv
